>>> sv/ntc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric token classifier package
// Widths, character codes, lexer mode codes and token kind codes.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int CHAR_W      = 8;
  localparam int KIND_W      = 2;
  localparam int OUT_W       = 64;
  localparam int MODE_W      = 3;
  localparam int SUM_W       = VALUE_WIDTH + 4;

  localparam logic [VALUE_WIDTH-1:0] CAP     = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] MAX_POS = ~CAP;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_EXP_L = 8'h65;
  localparam logic [CHAR_W-1:0] CH_EXP_U = 8'h45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [MODE_W-1:0] MODE_START      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AFTER_SIGN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NEED_DIGIT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BODY       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AFTER_EXP  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SYMBOL     = 3'd5;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_INTEGER = 2'd0;
  localparam kind_t KIND_REAL    = 2'd1;
  localparam kind_t KIND_SYMBOL  = 2'd2;

endpackage

>>> sv/numeric_token_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric token classifier
// Lexes a token one byte per beat and reports integer, real or symbol, with
// the saturated signed value of an integer token.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel char_valid/char_ready carries one byte of token text per
//   beat in char_code, with last_char high on the final byte of a token.
//   Output channel result_valid/result_ready carries one beat per token:
//   token_kind, int_value (zero unless integer) and overflow.
//   A byte is held in an input register, then one pass of mode update and
//   multiply-by-ten-plus-digit logic advances the token state; the result
//   register loads on the final byte; result_valid rises from the result
//   register once the byte has passed the input register. Throughput is one
//   byte per cycle, set by the single accumulate-and-compare path, unless
//   a final byte waits. When the receiver stalls, bytes that are not final
//   keep flowing; a final byte waits in the input register until the result
//   register frees up, and char_ready stays low while it waits.
//   Reset clears both registers' valid flags and returns the token state to
//   the start of a token.
// ----------------------------------------------------------------------------
module numeric_token_classifier (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ntc_pkg::CHAR_W-1:0]       char_code,
  input  logic                             last_char,
  input  logic                             char_valid,
  output logic                             char_ready,
  output ntc_pkg::kind_t                   token_kind,
  output logic signed [ntc_pkg::OUT_W-1:0] int_value,
  output logic                             overflow,
  output logic                             result_valid,
  input  logic                             result_ready
);
  import ntc_pkg::*;

  // input register
  logic              q_valid;
  logic [CHAR_W-1:0] q_char;
  logic              q_last;

  // token state
  logic [MODE_W-1:0]      mode, mode_next;
  logic                   point_seen, point_next;
  logic                   exp_seen, exp_next;
  logic                   negative, negative_next;
  logic [VALUE_WIDTH-1:0] magnitude, magnitude_next;
  logic                   saturated, saturated_next;

  // result register
  logic [VALUE_WIDTH-1:0] value_r, value_next;
  kind_t                  kind_next;
  logic                   ovf_next;

  logic             consume;
  logic             is_digit, is_sign, is_exp, take_digit;
  logic [SUM_W-1:0] mag_ext, acc_sum;
  logic             acc_over;

  assign consume    = q_valid && (!q_last || !result_valid || result_ready);
  assign char_ready = !q_valid || consume;

  always_comb begin
    is_sign = (q_char == CH_PLUS) || (q_char == CH_MINUS);
    is_exp  = (q_char == CH_EXP_L) || (q_char == CH_EXP_U);
    case (q_char) inside
      [CH_ZERO:CH_NINE]: is_digit = 1'b1;
      default:           is_digit = 1'b0;
    endcase
  end

  assign mag_ext  = {{(SUM_W-VALUE_WIDTH){1'b0}}, magnitude};
  assign acc_sum  = (mag_ext << 3) + (mag_ext << 1)
                  + SUM_W'(q_char - CH_ZERO);
  assign acc_over = acc_sum > {{(SUM_W-VALUE_WIDTH){1'b0}}, CAP};

  always_comb begin
    mode_next     = mode;
    point_next    = point_seen;
    exp_next      = exp_seen;
    negative_next = negative;
    take_digit    = 1'b0;
    case (mode)
      MODE_START: begin
        if (is_sign) begin
          negative_next = (q_char == CH_MINUS);
          mode_next     = MODE_AFTER_SIGN;
        end else if (q_char == CH_POINT) begin
          point_next = 1'b1;
          mode_next  = MODE_NEED_DIGIT;
        end else if (is_digit) begin
          take_digit = 1'b1;
          mode_next  = MODE_BODY;
        end else begin
          mode_next = MODE_SYMBOL;
        end
      end
      MODE_AFTER_SIGN: begin
        if (q_char == CH_POINT) begin
          point_next = 1'b1;
          mode_next  = MODE_NEED_DIGIT;
        end else if (is_digit) begin
          take_digit = 1'b1;
          mode_next  = MODE_BODY;
        end else begin
          mode_next = MODE_SYMBOL;
        end
      end
      MODE_NEED_DIGIT: begin
        if (is_digit) begin
          take_digit = 1'b1;
          mode_next  = MODE_BODY;
        end else begin
          mode_next = MODE_SYMBOL;
        end
      end
      MODE_BODY: begin
        if (is_digit) begin
          take_digit = 1'b1;
        end else if (q_char == CH_POINT && !point_seen) begin
          point_next = 1'b1;
        end else if (is_exp && !exp_seen) begin
          exp_next   = 1'b1;
          point_next = 1'b1;
          mode_next  = MODE_AFTER_EXP;
        end else begin
          mode_next = MODE_SYMBOL;
        end
      end
      MODE_AFTER_EXP: begin
        mode_next = (is_sign || is_digit) ? MODE_BODY : MODE_SYMBOL;
      end
      default: begin
        mode_next = MODE_SYMBOL;
      end
    endcase

    magnitude_next = magnitude;
    saturated_next = saturated;
    if (take_digit && !saturated) begin
      if (acc_over) begin
        magnitude_next = CAP;
        saturated_next = 1'b1;
      end else begin
        magnitude_next = acc_sum[VALUE_WIDTH-1:0];
      end
    end

    value_next = '0;
    ovf_next   = 1'b0;
    if (mode_next != MODE_BODY) begin
      kind_next = KIND_SYMBOL;
    end else if (point_next) begin
      kind_next = KIND_REAL;
    end else begin
      kind_next = KIND_INTEGER;
      if (negative_next) begin
        value_next = '0 - magnitude_next;
        ovf_next   = saturated_next;
      end else if (saturated_next || magnitude_next > MAX_POS) begin
        value_next = MAX_POS;
        ovf_next   = 1'b1;
      end else begin
        value_next = magnitude_next;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (char_ready) begin
      q_valid <= char_valid;
    end
    if (char_ready && char_valid) begin
      q_char <= char_code;
      q_last <= last_char;
    end
  end

  // token state: advance per byte, clear after the final byte
  always_ff @(posedge clk) begin
    if (rst || (consume && q_last)) begin
      mode       <= MODE_START;
      point_seen <= 1'b0;
      exp_seen   <= 1'b0;
      negative   <= 1'b0;
      magnitude  <= '0;
      saturated  <= 1'b0;
    end else if (consume) begin
      mode       <= mode_next;
      point_seen <= point_next;
      exp_seen   <= exp_next;
      negative   <= negative_next;
      magnitude  <= magnitude_next;
      saturated  <= saturated_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (consume && q_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (consume && q_last) begin
      token_kind <= kind_next;
      value_r    <= value_next;
      overflow   <= ovf_next;
    end
  end

  assign int_value = OUT_W'($signed(value_r));

  a_mag_bounded: assert property (@(posedge clk) disable iff (rst)
    magnitude <= CAP)
    else $error("magnitude above saturation cap");

  a_nonint_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && token_kind != KIND_INTEGER |-> int_value == '0 && !overflow)
    else $error("non-integer token carries a value");

  a_pos_ovf_max: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow && !value_r[VALUE_WIDTH-1] |-> value_r == MAX_POS)
    else $error("positive overflow not saturated to maximum");

  a_final_held: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_last && result_valid && !result_ready |=> q_valid && q_last)
    else $error("final byte dropped while result stalled");

endmodule
